### rtl/core/channel_record_deframer_core_defines.svh
// Assertion macros used by the checker file crd_checker.sv.
`ifndef CHANNEL_RECORD_DEFRAMER_CORE_DEFINES_SVH
`define CHANNEL_RECORD_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CRD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CRD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/crd_pkg.sv
`timescale 1ns / 1ps

package crd_pkg;

	localparam logic [15:0] CHANNEL_ID_RESET = 16'hAB01;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [12:0] {
		ST_HEADER  = 13'b0000000000001,
		ST_CHANNEL = 13'b0000000000010,
		ST_PEAK0   = 13'b0000000000100,
		ST_PEAK1   = 13'b0000000001000,
		ST_AREA0   = 13'b0000000010000,
		ST_AREA1   = 13'b0000000100000,
		ST_AREA2   = 13'b0000001000000,
		ST_AREA3   = 13'b0000010000000,
		ST_TIME0   = 13'b0000100000000,
		ST_TIME1   = 13'b0001000000000,
		ST_STATUS  = 13'b0010000000000,
		ST_DIV     = 13'b0100000000000,
		ST_LOAD    = 13'b1000000000000
	} state_t;

	typedef struct packed {
		logic shift_peak;
		logic shift_area;
		logic shift_time;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic hi_match;
		logic lo_match;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

### rtl/core/channel_record_deframer_core.sv
`timescale 1ns / 1ps

// Channel record deframer.
// in channel (in_valid/in_ready, rx_byte): one received byte per transaction.
// The block hunts for the two channel id bytes, then collects peak (2 bytes),
// area (4 bytes), transmit time (2 bytes) and a status byte, all big-endian.
// out channel (out_valid/out_ready): one record per status byte, carrying the
// fields plus intensity = area / transmit_time (0 with divide_by_zero set when
// the time is zero).
// cfg channel (cfg_valid/cfg_ready, cfg_data): writes channel_id; always ready.
// After the status byte the 32-step restoring divider runs and the record
// then loads into the output register in the load step, with in_ready low
// throughout. in_ready then returns high, so a new frame is parsed while the
// record waits. If the receiver stalls, the next record waits in the load
// step (in_ready low) until the output register is taken.
// Reset: channel_id returns to 0xAB01, parsing restarts at the header byte and
// out_valid clears.
module channel_record_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] peak,
	output logic [31:0] area,
	output logic [15:0] transmit_time,
	output logic [31:0] intensity,
	output logic [7:0]  status_byte,
	output logic        divide_by_zero
);

	crd_pkg::cmd_t  cmd;
	crd_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	crd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crd_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx_byte),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.peak           (peak),
		.area           (area),
		.transmit_time  (transmit_time),
		.intensity      (intensity),
		.status_byte    (status_byte),
		.divide_by_zero (divide_by_zero)
	);

endmodule

### rtl/core/crd_datapath.sv
`timescale 1ns / 1ps

module crd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_valid,
	input  logic [15:0]        cfg_data,
	input  crd_pkg::cmd_t      cmd,
	output crd_pkg::stat_t     stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        peak,
	output logic [31:0]        area,
	output logic [15:0]        transmit_time,
	output logic [31:0]        intensity,
	output logic [7:0]         status_byte,
	output logic               divide_by_zero
);

	logic [15:0] channel_id_q;
	logic [15:0] peak_acc_q;
	logic [31:0] area_acc_q;
	logic [15:0] time_acc_q;
	logic [7:0]  status_q;

	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] divisor_q;
	logic [crd_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic [16:0] rem_sh;
	logic [16:0] rem_diff;
	logic        q_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_id_q <= crd_pkg::CHANNEL_ID_RESET;
		end else if (cfg_valid) begin
			channel_id_q <= cfg_data;
		end
	end

	// Fields arrive big-endian: shift each accepted byte in at the bottom.
	always_ff @(posedge clk) begin
		if (cmd.shift_peak) begin
			peak_acc_q <= {peak_acc_q[7:0], rx_byte};
		end
		if (cmd.shift_area) begin
			area_acc_q <= {area_acc_q[23:0], rx_byte};
		end
		if (cmd.shift_time) begin
			time_acc_q <= {time_acc_q[7:0], rx_byte};
		end
		if (cmd.div_start) begin
			status_q <= rx_byte;
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign rem_sh   = {rem_q, quo_q[31]};
	assign rem_diff = rem_sh - {1'b0, divisor_q};
	assign q_bit    = !rem_diff[16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + crd_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q     <= area_acc_q;
			rem_q     <= '0;
			divisor_q <= time_acc_q;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[30:0], q_bit};
			rem_q <= q_bit ? rem_diff[15:0] : rem_sh[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			peak           <= peak_acc_q;
			area           <= area_acc_q;
			transmit_time  <= divisor_q;
			intensity      <= (divisor_q == 16'd0) ? 32'd0 : quo_q;
			status_byte    <= status_q;
			divide_by_zero <= (divisor_q == 16'd0);
		end
	end

	assign stat.hi_match = (rx_byte == channel_id_q[15:8]);
	assign stat.lo_match = (rx_byte == channel_id_q[7:0]);
	assign stat.div_last = (div_cnt_q == crd_pkg::DIV_CNT_W'(crd_pkg::DIV_STEPS - 1));
	assign stat.out_free = !out_valid || out_ready;

endmodule

### rtl/core/crd_ctrl.sv
`timescale 1ns / 1ps

module crd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  crd_pkg::stat_t stat,
	output crd_pkg::cmd_t  cmd
);

	crd_pkg::state_t state_q;
	crd_pkg::state_t state_nxt;
	logic            take;

	assign in_ready = !(state_q == crd_pkg::ST_DIV || state_q == crd_pkg::ST_LOAD);
	assign take     = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			crd_pkg::ST_HEADER: begin
				if (take && stat.hi_match) state_nxt = crd_pkg::ST_CHANNEL;
			end
			// hold here on a low-byte mismatch
			crd_pkg::ST_CHANNEL: begin
				if (take && stat.lo_match) state_nxt = crd_pkg::ST_PEAK0;
			end
			crd_pkg::ST_PEAK0: begin
				cmd.shift_peak = take;
				if (take) state_nxt = crd_pkg::ST_PEAK1;
			end
			crd_pkg::ST_PEAK1: begin
				cmd.shift_peak = take;
				if (take) state_nxt = crd_pkg::ST_AREA0;
			end
			crd_pkg::ST_AREA0: begin
				cmd.shift_area = take;
				if (take) state_nxt = crd_pkg::ST_AREA1;
			end
			crd_pkg::ST_AREA1: begin
				cmd.shift_area = take;
				if (take) state_nxt = crd_pkg::ST_AREA2;
			end
			crd_pkg::ST_AREA2: begin
				cmd.shift_area = take;
				if (take) state_nxt = crd_pkg::ST_AREA3;
			end
			crd_pkg::ST_AREA3: begin
				cmd.shift_area = take;
				if (take) state_nxt = crd_pkg::ST_TIME0;
			end
			crd_pkg::ST_TIME0: begin
				cmd.shift_time = take;
				if (take) state_nxt = crd_pkg::ST_TIME1;
			end
			crd_pkg::ST_TIME1: begin
				cmd.shift_time = take;
				if (take) state_nxt = crd_pkg::ST_STATUS;
			end
			crd_pkg::ST_STATUS: begin
				cmd.div_start = take;
				if (take) state_nxt = crd_pkg::ST_DIV;
			end
			crd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_nxt = crd_pkg::ST_LOAD;
			end
			// wait for the output register to free up
			crd_pkg::ST_LOAD: begin
				cmd.out_load = stat.out_free;
				if (stat.out_free) state_nxt = crd_pkg::ST_HEADER;
			end
			default: begin
				state_nxt = crd_pkg::ST_HEADER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crd_pkg::ST_HEADER;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### rtl/core/crd_checker.sv
`timescale 1ns / 1ps
`include "channel_record_deframer_core_defines.svh"

module crd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] peak,
	input logic [31:0] area,
	input logic [15:0] transmit_time,
	input logic [31:0] intensity,
	input logic        divide_by_zero
);

	`CRD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(peak) && $stable(area) && $stable(transmit_time) && $stable(intensity), "record changed while stalled")
	`CRD_ASSERT_IMP(a_new_rec_no_in, $rose(out_valid), !$past(in_valid && in_ready), "record appeared right after a byte transaction")
	`CRD_ASSERT_IMP(a_dz_zero, out_valid && divide_by_zero, intensity == 32'd0 && transmit_time == 16'd0, "divide_by_zero record inconsistent")
	`CRD_ASSERT_IMP(a_nz_time, out_valid && !divide_by_zero, transmit_time != 16'd0, "zero time without divide_by_zero")

endmodule

bind channel_record_deframer_core crd_checker u_crd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.peak           (peak),
	.area           (area),
	.transmit_time  (transmit_time),
	.intensity      (intensity),
	.divide_by_zero (divide_by_zero)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int PHASE_BYTES  = 230;
	localparam int NUM_PHASES   = 6;
	localparam int SETTLE_TICKS = 40;
	localparam int HOLDOFF_TICKS = 500;
	localparam int HOLDOFF_AT   = 12;

	typedef enum logic [3:0] {
		PS_HEADER,
		PS_CHANNEL,
		PS_PEAK_HI,
		PS_PEAK_LO,
		PS_AREA_0,
		PS_AREA_1,
		PS_AREA_2,
		PS_AREA_3,
		PS_TIME_HI,
		PS_TIME_LO,
		PS_STATUS
	} frame_state_e;

	typedef struct packed {
		logic [15:0] peak;
		logic [31:0] area;
		logic [15:0] transmit_time;
		logic [31:0] intensity;
		logic [7:0]  status_byte;
		logic        divide_by_zero;
	} record_t;

	class record_scoreboard;
		logic [15:0]  channel_id;
		frame_state_e state;
		logic [15:0]  peak_acc;
		logic [31:0]  area_acc;
		logic [15:0]  time_acc;
		record_t      expected_q[$];
		int           errors;
		int           bytes_seen;
		int           records_checked;
		int           zero_time_records;

		function new();
			channel_id = crd_pkg::CHANNEL_ID_RESET;
			state = PS_HEADER;
			peak_acc = '0;
			area_acc = '0;
			time_acc = '0;
			errors = 0;
			bytes_seen = 0;
			records_checked = 0;
			zero_time_records = 0;
		endfunction

		function void set_channel_id(logic [15:0] id);
			channel_id = id;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Advance the frame parser by one accepted byte.
		function void note_byte(logic [7:0] b);
			record_t rec;
			bytes_seen++;
			case (state)
				PS_HEADER: if (b == channel_id[15:8]) state = PS_CHANNEL;
				PS_CHANNEL: if (b == channel_id[7:0]) state = PS_PEAK_HI;
				PS_PEAK_HI: begin
					peak_acc = {8'h00, b};
					state = PS_PEAK_LO;
				end
				PS_PEAK_LO: begin
					peak_acc = {peak_acc[7:0], b};
					state = PS_AREA_0;
				end
				PS_AREA_0: begin
					area_acc = {24'h000000, b};
					state = PS_AREA_1;
				end
				PS_AREA_1: begin
					area_acc = {area_acc[23:0], b};
					state = PS_AREA_2;
				end
				PS_AREA_2: begin
					area_acc = {area_acc[23:0], b};
					state = PS_AREA_3;
				end
				PS_AREA_3: begin
					area_acc = {area_acc[23:0], b};
					state = PS_TIME_HI;
				end
				PS_TIME_HI: begin
					time_acc = {8'h00, b};
					state = PS_TIME_LO;
				end
				PS_TIME_LO: begin
					time_acc = {time_acc[7:0], b};
					state = PS_STATUS;
				end
				PS_STATUS: begin
					rec.peak = peak_acc;
					rec.area = area_acc;
					rec.transmit_time = time_acc;
					rec.status_byte = b;
					if (time_acc == 16'h0000) begin
						rec.intensity = '0;
						rec.divide_by_zero = 1'b1;
					end else begin
						rec.intensity = area_acc / {16'h0000, time_acc};
						rec.divide_by_zero = 1'b0;
					end
					expected_q = {expected_q, rec};
					state = PS_HEADER;
				end
				default: state = PS_HEADER;
			endcase
		endfunction

		function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_record(record_t got);
			record_t exp_r;
			if (expected_q.size() == 0) begin
				$error("record with no pending transaction: peak 0x%0h area 0x%0h",
					got.peak, got.area);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			records_checked++;
			if (exp_r.divide_by_zero) zero_time_records++;
			check_field("peak", 32'(exp_r.peak), 32'(got.peak));
			check_field("area", exp_r.area, got.area);
			check_field("transmit_time", 32'(exp_r.transmit_time),
				32'(got.transmit_time));
			check_field("intensity", exp_r.intensity, got.intensity);
			check_field("status_byte", 32'(exp_r.status_byte), 32'(got.status_byte));
			check_field("divide_by_zero", 32'(exp_r.divide_by_zero),
				32'(got.divide_by_zero));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] peak;
	logic [31:0] area;
	logic [15:0] transmit_time;
	logic [31:0] intensity;
	logic [7:0]  status_byte;
	logic        divide_by_zero;

	bit idle_on = 1'b1;
	int id_settings = 1;
	record_scoreboard deframer_sb;

	channel_record_deframer_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.peak           (peak),
		.area           (area),
		.transmit_time  (transmit_time),
		.intensity      (intensity),
		.status_byte    (status_byte),
		.divide_by_zero (divide_by_zero)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		deframer_sb.note_byte(b);
	endtask

	// High id byte, optional wrong low bytes, the low id byte, then the nine payload bytes.
	task automatic send_frame(input logic [15:0] id, input logic [15:0] pk,
			input logic [31:0] ar, input logic [15:0] xmit, input logic [7:0] st,
			input int n_wrong_lo);
		send_byte(id[15:8]);
		repeat (n_wrong_lo) send_byte(id[7:0] ^ 8'($urandom_range(1, 255)));
		send_byte(id[7:0]);
		send_byte(pk[15:8]);
		send_byte(pk[7:0]);
		send_byte(ar[31:24]);
		send_byte(ar[23:16]);
		send_byte(ar[15:8]);
		send_byte(ar[7:0]);
		send_byte(xmit[15:8]);
		send_byte(xmit[7:0]);
		send_byte(st);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (deframer_sb.pending() != 0) @(posedge clk);
		// A partial frame produces no record; give the core time to finish anyway.
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_channel_id(input logic [15:0] id);
		cfg_valid <= 1'b1;
		cfg_data <= id;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		deframer_sb.set_channel_id(id);
		id_settings++;
	endtask

	function automatic logic [15:0] phase_channel_id(input int phase);
		case (phase)
			1: return 16'h0000;
			2: return 16'hFFFF;
			4: return 16'h00FF;
			6: return crd_pkg::CHANNEL_ID_RESET;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic run_random_phase(input logic [15:0] id);
		int sent;
		int pick;
		int n_wrong;
		int k;
		logic [15:0] pk;
		logic [31:0] ar;
		logic [15:0] xmit;
		sent = 0;
		while (sent < PHASE_BYTES) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				n_wrong = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
				case ($urandom_range(0, 3))
					0: pk = 16'hFFFF;
					1: pk = 16'h0000;
					default: pk = 16'($urandom());
				endcase
				case ($urandom_range(0, 7))
					0: ar = 32'hFFFF_FFFF;
					1, 2: ar = $urandom_range(0, 1000);
					default: ar = $urandom();
				endcase
				case ($urandom_range(0, 7))
					0: xmit = 16'h0000;
					1: xmit = 16'h0001;
					2: xmit = 16'hFFFF;
					3, 4: xmit = 16'($urandom_range(1, 255));
					default: xmit = 16'($urandom());
				endcase
				send_frame(id, pk, ar, xmit, 8'($urandom()), n_wrong);
				sent += 11 + n_wrong;
			end else if (pick == 8) begin
				k = $urandom_range(1, 5);
				repeat (k) send_byte(8'($urandom()));
				sent += k;
			end else begin
				// Broken frame: cut short, the next bytes land in its payload.
				k = $urandom_range(1, 8);
				send_byte(id[15:8]);
				send_byte(id[7:0]);
				repeat (k) send_byte(8'($urandom()));
				sent += 2 + k;
			end
		end
	endtask

	initial begin
		bit holdoff_done;
		int stall;
		record_t got;
		holdoff_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (!holdoff_done && deframer_sb.records_checked >= HOLDOFF_AT) begin
				holdoff_done = 1'b1;
				stall = HOLDOFF_TICKS;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.peak = peak;
			got.area = area;
			got.transmit_time = transmit_time;
			got.intensity = intensity;
			got.status_byte = status_byte;
			got.divide_by_zero = divide_by_zero;
			deframer_sb.check_record(got);
		end
	end

	initial begin
		deframer_sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: header miss, wrong low byte, all-ones frame with zero time,
		// then an all-zero frame divided by one.
		send_byte(8'h00);
		send_frame(crd_pkg::CHANNEL_ID_RESET, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 8'hFF, 1);
		send_frame(crd_pkg::CHANNEL_ID_RESET, 16'h0000, 32'h0000_0000, 16'h0001, 8'h00, 0);
		settle();

		for (int phase = 1; phase <= NUM_PHASES; phase++) begin
			logic [15:0] id;
			id = phase_channel_id(phase);
			write_channel_id(id);
			idle_on = !(phase == 2 || phase == 5);
			run_random_phase(id);
			settle();
		end

		$display("Covered %0d bytes and %0d records (%0d with zero transmit time)",
			deframer_sb.bytes_seen, deframer_sb.records_checked,
			deframer_sb.zero_time_records);
		$display("across %0d channel id settings, including one long output stall.",
			id_settings);
		if (deframer_sb.errors == 0 && deframer_sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
